// ===== rtl/core/xtec_pkg.sv =====
// Shared types and constants for the XML text escaper.
// Token and job structures, entity spelling and decimal conversion helpers.
// No dependencies.
package xtec_pkg;

  typedef enum logic [2:0] {
    TK_CHAR,
    TK_LT,
    TK_GT,
    TK_AMP,
    TK_QUOT,
    TK_REF
  } tok_kind_e;

  typedef struct packed {
    tok_kind_e   kind;
    logic [20:0] val;
  } tok_t;

  localparam int unsigned MaxTok = 4;

  typedef struct packed {
    tok_t [MaxTok-1:0] tok;
    logic [2:0]        cnt;
  } job_t;

  // reference phases
  localparam logic [2:0] PosAmp  = 3'd0;
  localparam logic [2:0] PosHash = 3'd1;
  localparam logic [2:0] PosDig  = 3'd2;
  localparam logic [2:0] PosSemi = 3'd3;

  localparam logic [7:0] ChAmp  = 8'h26;
  localparam logic [7:0] ChHash = 8'h23;
  localparam logic [7:0] ChSemi = 8'h3B;
  localparam logic [7:0] ChZero = 8'h30;

  function automatic logic [2:0] ent_len(input tok_kind_e kind);
    case (kind)
      TK_LT:   return 3'd4;
      TK_GT:   return 3'd4;
      TK_AMP:  return 3'd5;
      TK_QUOT: return 3'd6;
      default: return 3'd1;
    endcase
  endfunction

  function automatic logic [7:0] ent_byte(input tok_kind_e kind, input logic [2:0] pos);
    logic [7:0] c;
    c = ChSemi;
    if (pos == 3'd0) begin
      c = ChAmp;
    end else begin
      case (kind)
        TK_LT: begin
          case (pos)
            3'd1:    c = "l";
            3'd2:    c = "t";
            default: c = ChSemi;
          endcase
        end
        TK_GT: begin
          case (pos)
            3'd1:    c = "g";
            3'd2:    c = "t";
            default: c = ChSemi;
          endcase
        end
        TK_AMP: begin
          case (pos)
            3'd1:    c = "a";
            3'd2:    c = "m";
            3'd3:    c = "p";
            default: c = ChSemi;
          endcase
        end
        TK_QUOT: begin
          case (pos)
            3'd1:    c = "q";
            3'd2:    c = "u";
            3'd3:    c = "o";
            3'd4:    c = "t";
            default: c = ChSemi;
          endcase
        end
        default: c = ChSemi;
      endcase
    end
    return c;
  endfunction

  function automatic logic [23:0] pow10(input logic [2:0] k);
    case (k)
      3'd0:    return 24'd1;
      3'd1:    return 24'd10;
      3'd2:    return 24'd100;
      3'd3:    return 24'd1000;
      3'd4:    return 24'd10000;
      3'd5:    return 24'd100000;
      3'd6:    return 24'd1000000;
      default: return 24'd10000000;
    endcase
  endfunction

  // index of the leading decimal digit
  function automatic logic [2:0] ndig(input logic [20:0] v);
    logic [2:0] n;
    n = '0;
    for (int i = 1; i < 7; i++) begin
      if ({3'b0, v} >= pow10(3'(i))) n = n + 3'd1;
    end
    return n;
  endfunction

endpackage

// ===== rtl/core/xtec_front.sv =====
// Input stage of the XML text escaper: classifies each byte, runs UTF-8 decoding
// and builds a job of up to four tokens. Depends on xtec_pkg.
module xtec_front import xtec_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       html_i,
  input  logic       utf8_i,
  input  logic [7:0] byte_i,
  input  logic       take_i,
  output job_t       job_o,
  output logic       has_job_o
);

  logic [7:0]  held_q [MaxTok];
  logic [2:0]  cnt_q, cnt_d;
  logic [1:0]  rem_q, rem_d;
  logic [20:0] acc_q, acc_d;

  logic        held_we;
  logic [1:0]  held_wi;

  logic        fr_has, fr_start;
  tok_t        fr_tok;
  logic [1:0]  fr_rem;
  logic [20:0] fr_acc;

  logic        prefix, tail_has;
  tok_t        tail_tok;
  logic [2:0]  base;
  logic [20:0] acc_n;
  logic [1:0]  rem_n;

  function automatic logic char_ok(input logic [20:0] v);
    return (v == 21'h09) || (v == 21'h0A) || (v == 21'h0D) ||
           ((v >= 21'h20) && (v != 21'h0FFFE) && (v != 21'h0FFFF));
  endfunction

  // single byte outside any sequence
  always_comb begin
    fr_has      = 1'b1;
    fr_start    = 1'b0;
    fr_tok.kind = TK_CHAR;
    fr_tok.val  = {13'b0, byte_i};
    fr_rem      = '0;
    fr_acc      = '0;
    if (byte_i == 8'h3C) begin
      fr_tok.kind = TK_LT;
    end else if (byte_i == 8'h3E) begin
      fr_tok.kind = TK_GT;
    end else if (byte_i == 8'h26) begin
      fr_tok.kind = TK_AMP;
    end else if (byte_i == 8'h22) begin
      fr_tok.kind = TK_QUOT;
    end else if ((byte_i >= 8'h20 && byte_i < 8'h80) ||
                 (byte_i inside {8'h09, 8'h0A, 8'h0D})) begin
      fr_tok.kind = TK_CHAR;
    end else if (byte_i < 8'h80) begin
      fr_has = 1'b0;
    end else if (html_i || !utf8_i || byte_i < 8'hC0 || byte_i >= 8'hF8) begin
      fr_tok.kind = TK_REF;
    end else begin
      fr_has   = 1'b0;
      fr_start = 1'b1;
      if (byte_i < 8'hE0) begin
        fr_rem = 2'd1;
        fr_acc = {16'b0, byte_i[4:0]};
      end else if (byte_i < 8'hF0) begin
        fr_rem = 2'd2;
        fr_acc = {17'b0, byte_i[3:0]};
      end else begin
        fr_rem = 2'd3;
        fr_acc = {18'b0, byte_i[2:0]};
      end
    end
  end

  assign acc_n = {acc_q[14:0], byte_i[5:0]};
  assign rem_n = rem_q - 2'd1;

  always_comb begin
    prefix   = 1'b0;
    tail_has = 1'b0;
    tail_tok = fr_tok;
    held_we  = 1'b0;
    held_wi  = '0;
    cnt_d    = cnt_q;
    rem_d    = rem_q;
    acc_d    = acc_q;
    if (byte_i == 8'h00) begin
      tail_has      = 1'b1;
      tail_tok.kind = TK_CHAR;
      tail_tok.val  = '0;
      cnt_d = '0;
      rem_d = '0;
      acc_d = '0;
    end else if (rem_q != 2'd0 && byte_i[7:6] == 2'b10) begin
      held_we = 1'b1;
      held_wi = cnt_q[1:0];
      cnt_d   = cnt_q + 3'd1;
      acc_d   = acc_n;
      rem_d   = rem_n;
      if (rem_n == 2'd0) begin
        cnt_d    = '0;
        acc_d    = '0;
        tail_has = 1'b1;
        if (char_ok(acc_n)) begin
          tail_tok.kind = TK_REF;
          tail_tok.val  = acc_n;
        end else begin
          prefix        = 1'b1;
          tail_tok.kind = TK_REF;
          tail_tok.val  = {13'b0, byte_i};
        end
      end
    end else begin
      prefix   = (rem_q != 2'd0);
      tail_has = fr_has;
      cnt_d    = '0;
      rem_d    = '0;
      acc_d    = '0;
      if (fr_start) begin
        held_we = 1'b1;
        held_wi = '0;
        cnt_d   = 3'd1;
        rem_d   = fr_rem;
        acc_d   = fr_acc;
      end
    end
  end

  assign base = prefix ? cnt_q : 3'd0;

  always_comb begin
    for (int i = 0; i < MaxTok; i++) begin
      job_o.tok[i].kind = TK_REF;
      job_o.tok[i].val  = '0;
      if (prefix && 3'(i) < cnt_q) begin
        job_o.tok[i].val = {13'b0, held_q[i]};
      end else if (3'(i) == base) begin
        job_o.tok[i] = tail_tok;
      end
    end
    job_o.cnt = base + {2'b0, tail_has};
  end

  assign has_job_o = (job_o.cnt != 3'd0);

  always_ff @(posedge clk_i) begin
    if (take_i && held_we) begin
      held_q[held_wi] <= byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rem_q <= '0;
      acc_q <= '0;
    end else if (take_i) begin
      cnt_q <= cnt_d;
      rem_q <= rem_d;
      acc_q <= acc_d;
    end
  end

  property p_pending_fits;
    @(posedge clk_i) disable iff (!rst_ni)
      (rem_q != 2'd0) |-> (cnt_q != 3'd0 && ({1'b0, cnt_q} + {2'b0, rem_q}) <= 4'd4);
  endproperty
  a_pending_fits: assert property (p_pending_fits) else $error("pending sequence overflow");

  property p_idle_clear;
    @(posedge clk_i) disable iff (!rst_ni)
      (rem_q == 2'd0) |-> (cnt_q == 3'd0 && acc_q == 21'd0);
  endproperty
  a_idle_clear: assert property (p_idle_clear) else $error("stale decode state");

  property p_nul_single;
    @(posedge clk_i) disable iff (!rst_ni)
      (take_i && byte_i == 8'h00) |=> (rem_q == 2'd0);
  endproperty
  a_nul_single: assert property (p_nul_single) else $error("sequence survives terminator");

endmodule

// ===== rtl/core/xtec_emit.sv =====
// XML text escaper output stage: walks job tokens one byte per cycle unless stalled,
// spells entities and decimal references, and holds the output register. Uses xtec_pkg.
module xtec_emit import xtec_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  job_t       job_i,
  input  logic       load_i,
  output logic       take_ok_o,
  output logic       out_valid_o,
  output logic [7:0] out_byte_o,
  output logic       out_last_o,
  input  logic       out_ready_i
);

  job_t        job_q;
  logic        job_valid_q;
  logic [1:0]  tok_q;
  logic [2:0]  pos_q;
  logic [20:0] r_q;
  logic [2:0]  k_q;
  logic        out_valid_q;
  logic [7:0]  out_byte_q;
  logic        out_last_q;

  tok_t        cur;
  logic [7:0]  cur_byte;
  logic        tok_end, job_end, out_load, step, done_now;
  logic [23:0] p, prod, sub;
  logic [3:0]  dig;

  assign cur = job_q.tok[tok_q];
  assign p   = pow10(k_q);

  always_comb begin
    dig  = '0;
    sub  = '0;
    prod = '0;
    for (int d = 1; d < 10; d++) begin
      prod = 24'(d) * p;
      if ({3'b0, r_q} >= prod) begin
        dig = 4'(d);
        sub = prod;
      end
    end
  end

  always_comb begin
    cur_byte = cur.val[7:0];
    tok_end  = 1'b1;
    case (cur.kind)
      TK_CHAR: begin
        cur_byte = cur.val[7:0];
        tok_end  = 1'b1;
      end
      TK_LT, TK_GT, TK_AMP, TK_QUOT: begin
        cur_byte = ent_byte(cur.kind, pos_q);
        tok_end  = (pos_q == ent_len(cur.kind) - 3'd1);
      end
      TK_REF: begin
        case (pos_q)
          PosAmp: begin
            cur_byte = ChAmp;
            tok_end  = 1'b0;
          end
          PosHash: begin
            cur_byte = ChHash;
            tok_end  = 1'b0;
          end
          PosDig: begin
            cur_byte = ChZero + {4'b0, dig};
            tok_end  = 1'b0;
          end
          default: begin
            cur_byte = ChSemi;
            tok_end  = 1'b1;
          end
        endcase
      end
      default: begin
        cur_byte = cur.val[7:0];
        tok_end  = 1'b1;
      end
    endcase
  end

  assign job_end  = tok_end && ({1'b0, tok_q} == job_q.cnt - 3'd1);
  assign out_load = !out_valid_q || out_ready_i;
  assign step     = job_valid_q && out_load;
  assign done_now = step && job_end;

  assign take_ok_o = !job_valid_q || done_now;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      job_q <= job_i;
    end
    if (step) begin
      out_byte_q <= cur_byte;
      out_last_q <= job_end;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
      tok_q       <= '0;
      pos_q       <= '0;
      r_q         <= '0;
      k_q         <= '0;
    end else begin
      if (step) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      if (load_i) begin
        job_valid_q <= 1'b1;
        tok_q       <= '0;
        pos_q       <= '0;
      end else if (done_now) begin
        job_valid_q <= 1'b0;
      end else if (step) begin
        if (tok_end) begin
          tok_q <= tok_q + 2'd1;
          pos_q <= '0;
        end else if (cur.kind == TK_REF) begin
          case (pos_q)
            PosAmp: pos_q <= PosHash;
            PosHash: begin
              pos_q <= PosDig;
              r_q   <= cur.val;
              k_q   <= ndig(cur.val);
            end
            PosDig: begin
              r_q <= r_q - sub[20:0];
              if (k_q == 3'd0) begin
                pos_q <= PosSemi;
              end else begin
                k_q <= k_q - 3'd1;
              end
            end
            default: pos_q <= PosSemi;
          endcase
        end else begin
          pos_q <= pos_q + 3'd1;
        end
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;

  property p_tok_in_job;
    @(posedge clk_i) disable iff (!rst_ni)
      job_valid_q |-> ({1'b0, tok_q} < job_q.cnt);
  endproperty
  a_tok_in_job: assert property (p_tok_in_job) else $error("token index past job");

  property p_digit_range;
    @(posedge clk_i) disable iff (!rst_ni)
      (job_valid_q && cur.kind == TK_REF && pos_q == PosDig) |->
        ({3'b0, r_q} < pow10(k_q + 3'd1));
  endproperty
  a_digit_range: assert property (p_digit_range) else $error("digit remainder too large");

  property p_ent_pos;
    @(posedge clk_i) disable iff (!rst_ni)
      (job_valid_q && (cur.kind == TK_LT || cur.kind == TK_GT ||
                       cur.kind == TK_AMP || cur.kind == TK_QUOT)) |->
        (pos_q < ent_len(cur.kind));
  endproperty
  a_ent_pos: assert property (p_ent_pos) else $error("entity position past end");

endmodule

// ===== rtl/core/xml_text_escape_utf8_charref.sv =====
// Top level of the XML text escaper with UTF-8 numeric character references.
// Holds the APB registers and joins xtec_front and xtec_emit. Uses xtec_pkg.
//
// Usage:
//   Text bytes enter on the s_axis channel, one byte per transaction; a zero
//   byte ends the string. Escaped text leaves on m_axis, one byte per
//   transaction, with tlast on the final byte caused by each input byte.
//   Bytes causing no output (control bytes, bytes inside a UTF-8 sequence)
//   are taken and produce no transaction.
//   An input byte's job passes the job register, then the output register.
//   The output stage emits one byte per cycle while m_axis does not stall:
//   a copied byte yields one byte, an entity four to six, a reference of
//   D digits D+3. The next input byte is taken in the cycle the current
//   job's last byte moves into the output register, so plain text runs at
//   one byte per cycle without stalls. When m_axis stalls, the output
//   register holds and s_axis_tready falls once the job register is occupied.
//   Reset clears the registers (html_mode, utf8_input both 0), any pending
//   sequence and both pipeline stages. Registers: html_mode at 0x0,
//   utf8_input at 0x4; write only while idle.
module xml_text_escape_utf8_charref import xtec_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
  output logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic html_q, utf8_q;
  logic take, take_ok, has_job;
  job_t job;

  assign pready = 1'b1;
  assign prdata = {31'b0, paddr[2] ? utf8_q : html_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      html_q <= 1'b0;
      utf8_q <= 1'b0;
    end else if (psel && penable && pwrite) begin
      if (paddr[2]) begin
        utf8_q <= pwdata[0];
      end else begin
        html_q <= pwdata[0];
      end
    end
  end

  assign s_axis_tready = take_ok;
  assign take          = s_axis_tvalid && take_ok;

  xtec_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .html_i    (html_q),
    .utf8_i    (utf8_q),
    .byte_i    (s_axis_tdata),
    .take_i    (take),
    .job_o     (job),
    .has_job_o (has_job)
  );

  xtec_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (job),
    .load_i      (take && has_job),
    .take_ok_o   (take_ok),
    .out_valid_o (m_axis_tvalid),
    .out_byte_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast),
    .out_ready_i (m_axis_tready)
  );

endmodule

// ===== sim/tb_xml_text_escape_utf8_charref.sv =====
// Testbench for xml_text_escape_utf8_charref: drives text bytes and APB writes,
// predicts the escaped byte stream and checks it on m_axis with random stalls.
// Depends on xtec_pkg and the RTL of the block only.
`timescale 1ns / 100ps

module tb_xml_text_escape_utf8_charref;
  import xtec_pkg::*;

  localparam logic [2:0] RegHtml = 3'h0;
  localparam logic [2:0] RegUtf8 = 3'h4;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
  } esc_byte_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // [7:0] in_byte
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;        // [7:0] out_byte
  logic        m_axis_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // escaper state as seen by the predictor
  bit          cfg_html;
  bit          cfg_utf8;
  bit [7:0]    held [4];
  bit [2:0]    held_cnt;
  bit [1:0]    pend_left;
  bit [20:0]   acc;

  esc_byte_t   escaped_q [$];
  int          step_cnt;
  int          err_cnt;
  int          sent_cnt;
  int          send_gap_pct;
  int          recv_gap_pct;
  int          hold_left;

  xml_text_escape_utf8_charref i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------- predictor

  task automatic emit_byte(input bit [7:0] b);
    esc_byte_t e;
    if (step_cnt < 24) begin
      e.out_byte = b;
      e.run_last = 1'b0;
      escaped_q.push_back(e);
      step_cnt++;
    end
  endtask

  task automatic emit_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) emit_byte(s[i]);
  endtask

  task automatic emit_charref(input bit [20:0] v);
    bit [7:0]  dig [8];
    bit [20:0] r;
    int        k;
    r = v;
    k = 0;
    do begin
      dig[k] = ChZero + 8'(r % 10);
      r = r / 10;
      k++;
    end while (r != 0 && k < 8);
    emit_byte(ChAmp);
    emit_byte(ChHash);
    while (k > 0) begin
      k--;
      emit_byte(dig[k]);
    end
    emit_byte(ChSemi);
  endtask

  function automatic bit xml_char_ok(input bit [20:0] v);
    if (v == 21'h09 || v == 21'h0A || v == 21'h0D) return 1'b1;
    return v >= 21'h20 && v != 21'hFFFE && v != 21'hFFFF;
  endfunction

  task automatic drop_pending();
    held_cnt = '0;
    pend_left = '0;
    acc = '0;
  endtask

  task automatic flush_held();
    int i;
    for (i = 0; i < held_cnt && i < 4; i++) emit_charref({13'b0, held[i]});
    drop_pending();
  endtask

  task automatic escape_fresh(input bit [7:0] b);
    if (b == "<") begin
      emit_text("&lt;");
    end else if (b == ">") begin
      emit_text("&gt;");
    end else if (b == "&") begin
      emit_text("&amp;");
    end else if (b == "\"") begin
      emit_text("&quot;");
    end else if ((b >= 8'h20 && b < 8'h80) || b == 8'h09 || b == 8'h0A || b == 8'h0D) begin
      emit_byte(b);
    end else if (b < 8'h80) begin
      // control byte, dropped
    end else if (cfg_html || !cfg_utf8 || b < 8'hC0 || b >= 8'hF8) begin
      emit_charref({13'b0, b});
    end else begin
      held[0] = b;
      held_cnt = 3'd1;
      if (b < 8'hE0) begin
        pend_left = 2'd1;
        acc = {16'b0, b[4:0]};
      end else if (b < 8'hF0) begin
        pend_left = 2'd2;
        acc = {17'b0, b[3:0]};
      end else begin
        pend_left = 2'd3;
        acc = {18'b0, b[2:0]};
      end
    end
  endtask

  task automatic predict_escape(input bit [7:0] b);
    int        start;
    esc_byte_t e;
    start = escaped_q.size();
    step_cnt = 0;
    if (b == 8'h00) begin
      drop_pending();
      emit_byte(8'h00);
    end else if (pend_left != 0) begin
      if (b[7:6] == 2'b10) begin
        held[held_cnt[1:0]] = b;
        held_cnt = held_cnt + 3'd1;
        acc = {acc[14:0], b[5:0]};
        pend_left = pend_left - 2'd1;
        if (pend_left == 0) begin
          if (xml_char_ok(acc)) begin
            emit_charref(acc);
            drop_pending();
          end else begin
            flush_held();
          end
        end
      end else begin
        flush_held();
        escape_fresh(b);
      end
    end else begin
      escape_fresh(b);
    end
    if (escaped_q.size() > start) begin
      e = escaped_q.pop_back();
      e.run_last = 1'b1;
      escaped_q.push_back(e);
    end
  endtask

  // ------------------------------------------------------------------ checker

  task automatic note_mismatch(input string msg);
    err_cnt++;
    if (err_cnt <= 10) $display("%0t: mismatch: %s", $realtime, msg);
  endtask

  task automatic check_out(input logic [7:0] d, input logic l);
    esc_byte_t e;
    if (escaped_q.size() == 0) begin
      note_mismatch($sformatf("unexpected byte %h last %b", d, l));
    end else begin
      e = escaped_q.pop_front();
      if (e.out_byte !== d || e.run_last !== l)
        note_mismatch($sformatf("expected byte %h last %b, got byte %h last %b",
                                e.out_byte, e.run_last, d, l));
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) check_out(m_axis_tdata, m_axis_tlast);
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_gap_pct);
    end
  end

  // ----------------------------------------------------------------- drivers

  task automatic send_byte(input bit [7:0] b);
    while ($urandom_range(99) < send_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_escape(b);
    sent_cnt++;
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (escaped_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // write, then read back
  task automatic apb_write(input logic [2:0] a, input logic [31:0] d);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= a;
    pwdata  <= d;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (a == RegHtml) cfg_html = d[0];
    else cfg_utf8 = d[0];
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== {31'b0, d[0]})
      note_mismatch($sformatf("register %h read %h, expected %h", a, prdata, d[0]));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_idling(input int s, input int r);
    send_gap_pct = s;
    recv_gap_pct = r;
  endtask

  // ---------------------------------------------------------------- stimulus

  function automatic bit [7:0] random_text_byte();
    int r;
    r = $urandom_range(99);
    if (r < 45) return 8'($urandom_range(8'h7E, 8'h20));
    if (r < 55) begin
      case ($urandom_range(3))
        0:       return "<";
        1:       return ">";
        2:       return "&";
        default: return "\"";
      endcase
    end
    if (r < 62) return 8'($urandom_range(8'h1F, 8'h01));
    if (r < 64) return 8'h00;
    return 8'($urandom_range(8'hFF, 8'h80));
  endfunction

  task automatic send_utf8_unit();
    int       r;
    int       n;
    int       conts;
    bit [7:0] lead;
    r = $urandom_range(99);
    if (r < 45) begin
      send_byte(random_text_byte());
    end else if (r < 85) begin
      n = $urandom_range(3, 1);
      case (n)
        1:       lead = 8'($urandom_range(8'hDF, 8'hC0));
        2:       lead = 8'($urandom_range(8'hEF, 8'hE0));
        default: lead = 8'($urandom_range(8'hF7, 8'hF0));
      endcase
      conts = (r >= 75) ? $urandom_range(n - 1, 0) : n;
      send_byte(lead);
      repeat (conts) send_byte(8'($urandom_range(8'hBF, 8'h80)));
    end else if (r < 92) begin
      send_byte(8'hEF);
      send_byte(8'hBF);
      send_byte($urandom_range(1) ? 8'hBE : 8'hBF);
    end else begin
      send_byte(8'($urandom_range(8'hBF, 8'h80)));
    end
  endtask

  task automatic test_ascii_escapes();
    bit [7:0] seq [12] = '{8'h3C, 8'h3E, 8'h26, 8'h22, 8'h20, 8'h7F,
                           8'h09, 8'h0D, 8'h01, 8'h80, 8'hFF, 8'h00};
    foreach (seq[i]) send_byte(seq[i]);
    wait_idle();
  endtask

  task automatic test_utf8_sequences();
    bit [7:0] seq [14] = '{8'hC3, 8'hA9, 8'hF7, 8'hBF, 8'hBF, 8'hBF, 8'h80,
                           8'hF8, 8'hC0, 8'h80, 8'hC3, 8'h41, 8'hE2, 8'h00};
    apb_write(RegUtf8, 32'd1);
    foreach (seq[i]) send_byte(seq[i]);
    // a pending sequence finishes under its own rule across a mode change
    send_byte(8'hE2);
    wait_idle();
    apb_write(RegHtml, 32'd1);
    send_byte(8'h82);
    send_byte(8'hAC);
    wait_idle();
    apb_write(RegHtml, 32'd0);
  endtask

  task automatic test_backpressure();
    int i;
    hold_left = 300;
    for (i = 0; i < 40; i++) send_byte((i % 2 == 0) ? "&" : random_text_byte());
    wait_idle();
  endtask

  task automatic test_random_phase(input int n, input bit h, input bit u);
    int  start;
    bit  paused;
    wait_idle();
    apb_write(RegHtml, {31'b0, h});
    apb_write(RegUtf8, {31'b0, u});
    start = sent_cnt;
    paused = 1'b0;
    while (sent_cnt - start < n) begin
      if (!paused && sent_cnt - start >= n / 2) begin
        wait_idle();
        paused = 1'b1;
      end
      if (cfg_utf8 && !cfg_html) send_utf8_unit();
      else send_byte(random_text_byte());
    end
    wait_idle();
  endtask

  initial begin
    set_idling(27, 45);
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_ascii_escapes();
    test_utf8_sequences();
    test_backpressure();
    test_random_phase(120, 1'b0, 1'b1);
    test_random_phase(40, 1'b1, 1'b1);
    set_idling(45, 27);
    test_random_phase(50, 1'b1, 1'b0);
    test_random_phase(50, 1'b0, 1'b0);
    test_random_phase(90, 1'b0, 1'b1);
    set_idling(0, 0);
    test_random_phase(90, 1'b0, 1'b1);

    wait_idle();
    repeat (20) @(posedge clk_i);
    if (err_cnt == 0 && escaped_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== xml_text_escape_utf8_charref.f =====
rtl/core/xtec_pkg.sv
rtl/core/xtec_front.sv
rtl/core/xtec_emit.sv
rtl/core/xml_text_escape_utf8_charref.sv
sim/tb_xml_text_escape_utf8_charref.sv
